/* rtl/dsr_pkg.sv */
// ----------------------------------------------------------------------------
// dsr_pkg
// Types, constants and small helper functions shared by the decimal result
// scale and round block.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int MANT_W    = 192;
  localparam int RES_W     = 96;
  localparam int REM_W     = 30;
  localparam int SCALE_W   = 6;
  localparam int CNT_W     = 8;
  localparam int MAX_SCALE = 28;
  localparam int BIG_STEP  = 9;

  // input request
  typedef struct packed {
    logic [63:0] mant_low;
    logic [63:0] mant_mid;
    logic [63:0] mant_high;
    logic [2:0]  top_word;
    logic [5:0]  in_scale;
    logic        in_sign;
    logic        sticky_in;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [63:0] res_low;
    logic [31:0] res_high;
    logic [4:0]  res_scale;
    logic        res_sign;
    logic        overflow;
  } out_req_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL,
    ST_DIV,
    ST_POST,
    ST_INC,
    ST_SSEL,
    ST_SDIV,
    ST_SPOST,
    ST_FIN
  } state_t;

  // trailing-zero strip stages
  typedef enum logic [1:0] {
    SG_TENK,
    SG_HUND,
    SG_TEN,
    SG_END
  } stage_t;

  // powers of ten up to 10^9
  function automatic logic [REM_W-1:0] pow10(input logic [3:0] idx);
    logic [REM_W-1:0] v;
    case (idx)
      4'd0:    v = 30'd1;
      4'd1:    v = 30'd10;
      4'd2:    v = 30'd100;
      4'd3:    v = 30'd1000;
      4'd4:    v = 30'd10000;
      4'd5:    v = 30'd100000;
      4'd6:    v = 30'd1000000;
      4'd7:    v = 30'd10000000;
      4'd8:    v = 30'd100000000;
      4'd9:    v = 30'd1000000000;
      default: v = 30'd1;
    endcase
    return v;
  endfunction

  // index of the highest nonzero 32-bit word, 0 for a zero value
  function automatic logic [2:0] top_index(input logic [MANT_W-1:0] v);
    logic [2:0] i;
    if (v[191:160] != '0) begin
      i = 3'd5;
    end else if (v[159:128] != '0) begin
      i = 3'd4;
    end else if (v[127:96] != '0) begin
      i = 3'd3;
    end else if (v[95:64] != '0) begin
      i = 3'd2;
    end else if (v[63:32] != '0) begin
      i = 3'd1;
    end else begin
      i = 3'd0;
    end
    return i;
  endfunction

endpackage

/* rtl/decimal_result_scale_round_core.sv */
// ----------------------------------------------------------------------------
// decimal_result_scale_round_core
// Scales a 192-bit decimal mantissa into 96 bits at scale 28 or below,
// rounding half to even, then strips trailing decimal zeros.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction
//  input   | in_valid, in_stall, in_data   | request in, stall out
//  result  | out_valid, out_stall, out_data| request out, stall in
//
// Every division pass runs on the shared bit-serial divider and goes through
// select, one shift step per dividend bit, the done flag and the post step.
// An item makes one such pass per scaling step and up to 9 strip passes,
// plus an increment per rounding carry and the accept, last select, skipped
// strip stages and finish; it takes longer while the output register is held.
// Input is stalled from acceptance until the result is loaded into the
// output register; a waiting result does not block the next request.
// Reset clears the sequencer and the output valid only.
// ----------------------------------------------------------------------------
module decimal_result_scale_round_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dsr_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dsr_pkg::out_req_t out_data
);
  import dsr_pkg::*;

  state_t             state_r, state_nxt;
  stage_t             stage_r, stage_nxt;
  logic [MANT_W-1:0]  mant_r, mant_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [2:0]         ht_r, ht_nxt;
  logic               sticky_r, sticky_nxt;
  logic               sign_r, sign_nxt;
  logic               ovf_r, ovf_nxt;
  logic [REM_W-1:0]   p_r, p_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_req_t           out_data_r, out_data_nxt;

  logic               div_start;
  div_stat_t          div_stat;
  logic [MANT_W-1:0]  div_quot;
  logic [REM_W-1:0]   div_rem;

  logic [MANT_W-1:0]  in_mant;
  logic [2:0]         in_ht;
  logic [2:0]         in_act;
  logic [2:0]         q_ht;
  logic [MANT_W-1:0]  mant_inc;
  logic [REM_W+1:0]   rnd_lhs;
  logic               rnd_up;
  logic               more;

  assign in_mant  = {in_data.mant_high, in_data.mant_mid, in_data.mant_low};
  assign in_act   = top_index(in_mant);
  assign in_ht    = (in_data.top_word > 3'd5) ? 3'd5 : in_data.top_word;
  assign q_ht     = top_index(div_quot);
  assign mant_inc = mant_r + 1'b1;
  assign rnd_lhs  = {1'b0, div_rem, 1'b0} + {{(REM_W+1){1'b0}}, (sticky_r | div_quot[0])};
  assign rnd_up   = rnd_lhs > {2'b00, p_r};
  assign more     = (q_ht >= 3'd3) || (scale_r > SCALE_W'(MAX_SCALE));

  // shared divider
  dsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mant_r),
    .divisor  (p_nxt),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    mant_nxt      = mant_r;
    scale_nxt     = scale_r;
    ht_nxt        = ht_r;
    sticky_nxt    = sticky_r;
    sign_nxt      = sign_r;
    ovf_nxt       = ovf_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mant_nxt   = in_mant;
          scale_nxt  = in_data.in_scale;
          sign_nxt   = in_data.in_sign;
          sticky_nxt = in_data.sticky_in;
          ovf_nxt    = 1'b0;
          ht_nxt     = (in_act > in_ht) ? in_act : in_ht;
          stage_nxt  = SG_TENK;
          state_nxt  = ST_SEL;
        end
      end

      // choose the next scaling step, or go on to the strip or flag overflow
      ST_SEL: begin
        if (!(ht_r >= 3'd3 || scale_r > SCALE_W'(MAX_SCALE))) begin
          state_nxt = ST_SSEL;
        end else if ((ht_r > 3'd3 && scale_r > SCALE_W'(BIG_STEP)) ||
                     scale_r > SCALE_W'(MAX_SCALE + BIG_STEP)) begin
          p_nxt     = pow10(4'd9);
          scale_nxt = scale_r - SCALE_W'(BIG_STEP);
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (scale_r > SCALE_W'(MAX_SCALE)) begin
          p_nxt     = pow10(4'(scale_r - SCALE_W'(MAX_SCALE)));
          scale_nxt = SCALE_W'(MAX_SCALE);
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (scale_r != '0) begin
          p_nxt     = pow10(4'd1);
          scale_nxt = scale_r - SCALE_W'(1);
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_POST;
        end
      end

      // sticky or round after a scaling pass
      ST_POST: begin
        mant_nxt = div_quot;
        ht_nxt   = q_ht;
        if (more) begin
          sticky_nxt = sticky_r | (div_rem != '0);
          state_nxt  = ST_SEL;
        end else if (rnd_up) begin
          state_nxt = ST_INC;
        end else begin
          state_nxt = ST_SEL;
        end
      end

      ST_INC: begin
        mant_nxt   = mant_inc;
        ht_nxt     = top_index(mant_inc);
        sticky_nxt = 1'b0;
        state_nxt  = ST_SEL;
      end

      // trailing zero strip: try 10^4 repeatedly, then 10^2, then 10
      ST_SSEL: begin
        case (stage_r)
          SG_TENK: begin
            if (scale_r >= SCALE_W'(4)) begin
              p_nxt     = pow10(4'd4);
              div_start = 1'b1;
              state_nxt = ST_SDIV;
            end else begin
              stage_nxt = SG_HUND;
            end
          end
          SG_HUND: begin
            if (scale_r >= SCALE_W'(2)) begin
              p_nxt     = pow10(4'd2);
              div_start = 1'b1;
              state_nxt = ST_SDIV;
            end else begin
              stage_nxt = SG_TEN;
            end
          end
          SG_TEN: begin
            if (scale_r != '0) begin
              p_nxt     = pow10(4'd1);
              div_start = 1'b1;
              state_nxt = ST_SDIV;
            end else begin
              stage_nxt = SG_END;
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end

      ST_SDIV: begin
        if (div_stat.done) begin
          state_nxt = ST_SPOST;
        end
      end

      ST_SPOST: begin
        state_nxt = ST_SSEL;
        if (div_rem == '0) begin
          mant_nxt = div_quot;
          case (stage_r)
            SG_TENK: scale_nxt = scale_r - SCALE_W'(4);
            SG_HUND: scale_nxt = scale_r - SCALE_W'(2);
            default: scale_nxt = scale_r - SCALE_W'(1);
          endcase
        end
        if (!(div_rem == '0 && stage_r == SG_TENK)) begin
          case (stage_r)
            SG_TENK: stage_nxt = SG_HUND;
            SG_HUND: stage_nxt = SG_TEN;
            default: stage_nxt = SG_END;
          endcase
        end
      end

      // load the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.res_sign  = sign_r;
          out_data_nxt.overflow  = ovf_r;
          out_data_nxt.res_low   = ovf_r ? '0 : mant_r[63:0];
          out_data_nxt.res_high  = ovf_r ? '0 : mant_r[RES_W-1:64];
          out_data_nxt.res_scale = ovf_r ? '0 : scale_r[4:0];
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= SG_TENK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mant_r     <= mant_nxt;
    scale_r    <= scale_nxt;
    ht_r       <= ht_nxt;
    sticky_r   <= sticky_nxt;
    sign_r     <= sign_nxt;
    ovf_r      <= ovf_nxt;
    p_r        <= p_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SEL))
    else $error("accepted request did not start the sequencer");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV || state_r == ST_SDIV))
    else $error("divider running outside a divide state");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.res_low == '0 && out_data.res_high == '0 && out_data.res_scale == '0))
    else $error("overflow result carries nonzero fields");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.res_scale <= 5'(MAX_SCALE)))
    else $error("result scale above limit");

endmodule

/* rtl/dsr_div.sv */
// ----------------------------------------------------------------------------
// dsr_div
// Bit-serial restoring divider: 192-bit dividend by a 30-bit divisor, one
// quotient bit per cycle. Quotient and remainder hold once finished.
// ----------------------------------------------------------------------------
module dsr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dsr_pkg::MANT_W-1:0]    dividend,
  input  logic [dsr_pkg::REM_W-1:0]     divisor,
  output dsr_pkg::div_stat_t            stat,
  output logic [dsr_pkg::MANT_W-1:0]    quot,
  output logic [dsr_pkg::REM_W-1:0]     rem
);
  import dsr_pkg::*;

  logic [MANT_W-1:0] q_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W:0]    trial;
  logic              ge;
  logic [REM_W:0]    diff;

  // one shift-subtract step
  always_comb begin
    trial = {rem_r, q_r[MANT_W-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MANT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[MANT_W-2:0], ge};
      rem_r <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;
  assign rem       = rem_r;

endmodule
